>>> sv/quadrature_sum_sqrt_assert.svh
// Assertion macros for the quadrature sum / square root pipeline.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef QUADRATURE_SUM_SQRT_ASSERT_SVH
`define QUADRATURE_SUM_SQRT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qss check failed");

// Next-cycle implication, disabled while reset is asserted.
`define QSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qss check failed");

`endif

>>> sv/qss_pkg.sv
// Shared widths, item type and root step table for the quadrature sum pipeline.
// No dependencies.
`timescale 1ns / 1ps

package qss_pkg;

    localparam int VALUE_W    = 32;       // input magnitude width
    localparam int MAG_W      = 16;       // magnitude bits that take part in the square
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int REM_W      = SUM_W + 1; // room for acc + step
    localparam int ROOT_W     = 17;
    localparam int ROOT_STEPS = ROOT_W;    // one result bit per stage

    localparam logic [ROOT_W-1:0] SAT_RESULT = ROOT_W'(17'd65535);
    localparam logic [ROOT_W-1:0] ROOT_MAX   = ROOT_W'(17'd92680);

    typedef struct packed {
        logic             sat;  // an input exceeded 16 bits
        logic [REM_W-1:0] rem;  // remainder of the radicand
        logic [REM_W-1:0] acc;  // partial root, scaled
    } t_qss_item;

    // Power of four used by root stage k: 4^(ROOT_STEPS-1-k).
    function automatic logic [REM_W-1:0] step_of(input int k);
        logic [REM_W-1:0] one;
        one = REM_W'(1);
        return one << (2 * (ROOT_STEPS - 1 - k));
    endfunction

endpackage

>>> sv/qss_square.sv
// Front end: saturation detect, squaring, then the exact 33-bit sum.
// Depends on qss_pkg and quadrature_sum_sqrt_assert.svh.
`timescale 1ns / 1ps
`include "quadrature_sum_sqrt_assert.svh"

module qss_square (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [qss_pkg::VALUE_W-1:0]   i_first_value,
    input  logic [qss_pkg::VALUE_W-1:0]   i_second_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output qss_pkg::t_qss_item            o_item
);
    import qss_pkg::*;

    // stage A: squares
    logic            r_valid_a;
    logic            r_sat_a;
    logic [SQ_W-1:0] r_sq_first;
    logic [SQ_W-1:0] r_sq_second;
    // stage B: sum
    logic            r_valid_b;
    t_qss_item       r_item_b;

    logic ready_a;
    logic ready_b;
    logic n_sat;

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign o_ready = ready_a;

    assign n_sat = (|i_first_value[VALUE_W-1:MAG_W]) || (|i_second_value[VALUE_W-1:MAG_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_sat_a     <= n_sat;
            r_sq_first  <= i_first_value[MAG_W-1:0] * i_first_value[MAG_W-1:0];
            r_sq_second <= i_second_value[MAG_W-1:0] * i_second_value[MAG_W-1:0];
        end
        if (ready_b && r_valid_a) begin
            r_item_b.sat <= r_sat_a;
            r_item_b.rem <= REM_W'(r_sq_first) + REM_W'(r_sq_second);
            r_item_b.acc <= '0;
        end
    end

    assign o_valid = r_valid_b;
    assign o_item  = r_item_b;

    // sum of two 32-bit squares never reaches bit 33
    `QSS_ASSERT_NOW(a_sum_fits, i_clk, i_rst_n, r_valid_b, !r_item_b.rem[REM_W-1])

endmodule

>>> sv/qss_root_stage.sv
// One digit of the restoring square root: compare, subtract, shift.
// Depends on qss_pkg and quadrature_sum_sqrt_assert.svh.
`timescale 1ns / 1ps
`include "quadrature_sum_sqrt_assert.svh"

module qss_root_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [qss_pkg::REM_W-1:0]     i_step,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  qss_pkg::t_qss_item            i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output qss_pkg::t_qss_item            o_item
);
    import qss_pkg::*;

    logic             r_valid;
    t_qss_item        r_item;
    t_qss_item        n_item;
    logic [REM_W-1:0] trial;
    logic             take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        trial      = i_item.acc + i_step;
        n_item.sat = i_item.sat;
        if (i_item.rem >= trial) begin
            n_item.rem = i_item.rem - trial;
            n_item.acc = (i_item.acc >> 1) + i_step;
        end else begin
            n_item.rem = i_item.rem;
            n_item.acc = i_item.acc >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    // remainder only shrinks; partial root never drops below half its old value
    `QSS_ASSERT_NEXT(a_rem_shrinks, i_clk, i_rst_n, take, r_item.rem <= $past(i_item.rem))
    `QSS_ASSERT_NEXT(a_acc_floor, i_clk, i_rst_n, take, r_item.acc >= ($past(i_item.acc) >> 1))

endmodule

>>> sv/quadrature_sum_sqrt.sv
// Top level: floor(sqrt(a^2 + b^2)) with 16-bit saturation, fully pipelined.
// Depends on qss_pkg, qss_square, qss_root_stage and quadrature_sum_sqrt_assert.svh.
`timescale 1ns / 1ps
`include "quadrature_sum_sqrt_assert.svh"

// Takes two unsigned 32-bit magnitudes per transfer and returns one 17-bit
// result per transfer: the floor of the square root of the exact 33-bit sum of
// their squares (0 to 92680), or 65535 when either input is above 65535.
// Throughput is one transfer per clock while i_ready does not stall the output.
// Squaring and summing each have a register, followed by one restoring-root
// stage per result bit (17 stages), each a single 34-bit compare and subtract.
// Every stage holds its own valid bit and advances whenever the stage after it
// is empty or draining, so bubbles collapse and input keeps flowing while a
// finished result waits in the last stage for i_ready.
module quadrature_sum_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [qss_pkg::VALUE_W-1:0]   i_first_value,
    input  logic [qss_pkg::VALUE_W-1:0]   i_second_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qss_pkg::ROOT_W-1:0]    o_root_result
);
    import qss_pkg::*;

    // Link k feeds root stage k; link ROOT_STEPS is the output stage.
    t_qss_item w_item  [ROOT_STEPS+1];
    logic      w_valid [ROOT_STEPS+1];
    logic      w_ready [ROOT_STEPS+1];

    qss_square u_square (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .o_valid        (w_valid[0]),
        .i_ready        (w_ready[0]),
        .o_item         (w_item[0])
    );

    // One result bit per stage, MSB first; the power of four is fixed per stage.
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        qss_root_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (step_of(k)),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_item  (w_item[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_item  (w_item[k+1])
        );
    end

    assign w_ready[ROOT_STEPS] = i_ready;
    assign o_valid             = w_valid[ROOT_STEPS];

    // Saturated items bypass the root value.
    assign o_root_result = w_item[ROOT_STEPS].sat ? SAT_RESULT
                                                  : w_item[ROOT_STEPS].acc[ROOT_W-1:0];

    // root of a sum of two 16-bit squares never exceeds 92680
    `QSS_ASSERT_NOW(a_result_range, i_clk, i_rst_n, o_valid, o_root_result <= ROOT_MAX)

endmodule
